// ===== src/sgd_pkg.sv =====
// sgd_pkg: shared types and constants of the skeleton swipe gesture detector.
// Used by sgd_front, sgd_back and the top level; depends on nothing.
`timescale 1ns / 1ps

package sgd_pkg;

    // Default timestamp width and the widths of the fixed fields
    localparam int TIME_WIDTH_DEF = 32;
    localparam int COORD_W        = 16;
    localparam int ID_W           = 4;
    localparam int IN_TIME_W      = 32;
    localparam int DUR_W          = 16;
    localparam int GESTURE_W      = 3;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_DUR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DUR = 2'd1;
    localparam logic [DUR_W-1:0] MIN_DUR_RESET = 16'd100;
    localparam logic [DUR_W-1:0] MAX_DUR_RESET = 16'd1000;

    // Queue depths between the parts
    localparam int MID_DEPTH = 4;
    localparam int OUT_DEPTH = 2;

    // Joint store layout
    localparam int NUM_JOINTS  = 10;
    localparam int J_HEAD      = 0;
    localparam int J_TORSO     = 1;
    localparam int J_LHAND     = 2;
    localparam int J_RHAND     = 3;
    localparam int J_LELBOW    = 4;
    localparam int J_RELBOW    = 5;
    localparam int J_LSHOULDER = 6;
    localparam int J_RSHOULDER = 7;
    localparam int J_LHIP      = 8;
    localparam int J_RHIP      = 9;

    // Detectors, in priority order
    localparam int NUM_DET = 6;
    localparam int D_LEFT  = 0;
    localparam int D_RIGHT = 1;
    localparam int D_UPL   = 2;
    localparam int D_UPR   = 3;
    localparam int D_DOWNL = 4;
    localparam int D_DOWNR = 5;

    typedef enum logic [GESTURE_W-1:0] {
        GEST_NONE  = 3'd0,
        GEST_LEFT  = 3'd1,
        GEST_RIGHT = 3'd2,
        GEST_UP    = 3'd3,
        GEST_DOWN  = 3'd4
    } t_gesture;

    // Joint-only classification of one frame; index 0 is the left hand side,
    // index 1 the right hand side.
    typedef struct packed {
        logic                      l_cancel;
        logic                      l_arm;
        logic                      l_end;
        logic                      r_cancel;
        logic                      r_arm;
        logic                      r_end;
        logic [1:0]                up_arm;
        logic [1:0]                up_end;
        logic [1:0]                dn_arm;
        logic [1:0]                dn_end;
        logic signed [COORD_W-1:0] hx_l;
        logic signed [COORD_W-1:0] hx_r;
        logic [COORD_W-1:0]        hip_half;
    } t_cls;

endpackage

// ===== src/sgd_fifo.sv =====
// sgd_fifo: small register queue with push/full and pop/empty sides.
// Standalone; used for the frame queue and the result queue.
`timescale 1ns / 1ps

module sgd_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_wr_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_rd_data,
    output logic             o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr;
    logic [PW-1:0]    r_rd_ptr;
    logic [CW-1:0]    r_count;
    logic             wr_en;
    logic             rd_en;

    assign o_full    = (r_count == CW'(DEPTH));
    assign o_empty   = (r_count == '0);
    assign wr_en     = i_push && !o_full;
    assign rd_en     = i_pop && !o_empty;
    assign o_rd_data = r_mem[r_rd_ptr];

    // Storage
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr_en) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (rd_en) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            r_count <= r_count + CW'(wr_en) - CW'(rd_en);
        end
    end

endmodule

// ===== src/sgd_front.sv =====
// sgd_front: joint store and per-frame classification of joint positions.
// Depends on sgd_pkg; feeds the frame queue read by sgd_back.
`timescale 1ns / 1ps

module sgd_front #(
    parameter int TIME_WIDTH = sgd_pkg::TIME_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_accept,
    input  logic [sgd_pkg::ID_W-1:0]            i_joint_id,
    input  logic signed [sgd_pkg::COORD_W-1:0]  i_joint_x,
    input  logic signed [sgd_pkg::COORD_W-1:0]  i_joint_y,
    input  logic [sgd_pkg::IN_TIME_W-1:0]       i_frame_time_ms,
    input  logic                                i_frame_end,
    output logic                                o_rec_push,
    output sgd_pkg::t_cls                       o_cls,
    output logic [TIME_WIDTH-1:0]               o_time
);

    localparam int CW = sgd_pkg::COORD_W;

    logic signed [CW-1:0] r_jx [sgd_pkg::NUM_JOINTS];
    logic signed [CW-1:0] r_jy [sgd_pkg::NUM_JOINTS];
    logic signed [CW-1:0] n_jx [sgd_pkg::NUM_JOINTS];
    logic signed [CW-1:0] n_jy [sgd_pkg::NUM_JOINTS];

    logic signed [CW-1:0] lhx, lhy, rhx, rhy;
    logic signed [CW:0]   r_side_a, r_side_b, hip_diff;
    logic [CW:0]          hip_abs;
    logic                 l_pos, r_pos;

    // Store update: the current beat's joint, ids above nine are dropped
    always_comb begin
        for (int j = 0; j < sgd_pkg::NUM_JOINTS; j++) begin
            n_jx[j] = r_jx[j];
            n_jy[j] = r_jy[j];
            if (i_accept && i_joint_id == sgd_pkg::ID_W'(j)) begin
                n_jx[j] = i_joint_x;
                n_jy[j] = i_joint_y;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < sgd_pkg::NUM_JOINTS; j++) begin
                r_jx[j] <= '0;
                r_jy[j] <= '0;
            end
        end else begin
            for (int j = 0; j < sgd_pkg::NUM_JOINTS; j++) begin
                r_jx[j] <= n_jx[j];
                r_jy[j] <= n_jy[j];
            end
        end
    end

    assign lhx = n_jx[sgd_pkg::J_LHAND];
    assign lhy = n_jy[sgd_pkg::J_LHAND];
    assign rhx = n_jx[sgd_pkg::J_RHAND];
    assign rhy = n_jy[sgd_pkg::J_RHAND];

    // Horizontal swipes: right hand sweeps left, left hand sweeps right
    assign l_pos    = rhx >= n_jx[sgd_pkg::J_RSHOULDER];
    assign r_pos    = lhx <= n_jx[sgd_pkg::J_LSHOULDER];
    assign r_side_a = $signed({lhx[CW-1], lhx})
                    - $signed({n_jx[sgd_pkg::J_LSHOULDER][CW-1], n_jx[sgd_pkg::J_LSHOULDER]});
    assign r_side_b = $signed({n_jx[sgd_pkg::J_LSHOULDER][CW-1], n_jx[sgd_pkg::J_LSHOULDER]})
                    - $signed({n_jx[sgd_pkg::J_TORSO][CW-1], n_jx[sgd_pkg::J_TORSO]});

    // Allowed sideways drift of a vertical swipe: half the hip spread
    assign hip_diff = $signed({n_jx[sgd_pkg::J_LHIP][CW-1], n_jx[sgd_pkg::J_LHIP]})
                    - $signed({n_jx[sgd_pkg::J_RHIP][CW-1], n_jx[sgd_pkg::J_RHIP]});
    assign hip_abs  = hip_diff[CW] ? (CW+1)'(-hip_diff) : hip_diff;

    always_comb begin
        o_cls.l_cancel = rhy < n_jy[sgd_pkg::J_RELBOW] || rhy > n_jy[sgd_pkg::J_HEAD]
                      || rhy < n_jy[sgd_pkg::J_RHIP]
                      || (l_pos && n_jx[sgd_pkg::J_TORSO] > n_jx[sgd_pkg::J_RSHOULDER]);
        o_cls.l_arm    = l_pos;
        o_cls.l_end    = rhx <= n_jx[sgd_pkg::J_TORSO];
        o_cls.r_cancel = lhy < n_jy[sgd_pkg::J_LELBOW] || lhy > n_jy[sgd_pkg::J_HEAD]
                      || lhy < n_jy[sgd_pkg::J_LHIP]
                      || (r_pos && r_side_a < r_side_b);
        o_cls.r_arm    = r_pos;
        o_cls.r_end    = lhx >= n_jx[sgd_pkg::J_TORSO];

        o_cls.up_arm[0] = lhy <= n_jy[sgd_pkg::J_LELBOW] && lhy <= n_jy[sgd_pkg::J_LHIP];
        o_cls.up_arm[1] = rhy <= n_jy[sgd_pkg::J_RELBOW] && rhy <= n_jy[sgd_pkg::J_RHIP];
        o_cls.up_end[0] = lhy > n_jy[sgd_pkg::J_LELBOW] && lhy > n_jy[sgd_pkg::J_LSHOULDER];
        o_cls.up_end[1] = rhy > n_jy[sgd_pkg::J_RELBOW] && rhy > n_jy[sgd_pkg::J_RSHOULDER];
        o_cls.dn_arm[0] = lhy >= n_jy[sgd_pkg::J_LELBOW] && lhy >= n_jy[sgd_pkg::J_LSHOULDER];
        o_cls.dn_arm[1] = rhy >= n_jy[sgd_pkg::J_RELBOW] && rhy >= n_jy[sgd_pkg::J_RSHOULDER];
        o_cls.dn_end[0] = lhy < n_jy[sgd_pkg::J_LELBOW] && lhy < n_jy[sgd_pkg::J_LHIP];
        o_cls.dn_end[1] = rhy < n_jy[sgd_pkg::J_RELBOW] && rhy < n_jy[sgd_pkg::J_RHIP];

        o_cls.hx_l     = lhx;
        o_cls.hx_r     = rhx;
        o_cls.hip_half = hip_abs[CW:1];
    end

    assign o_rec_push = i_accept && i_frame_end;
    assign o_time     = TIME_WIDTH'(i_frame_time_ms);

endmodule

// ===== src/sgd_back.sv =====
// sgd_back: the six swipe detectors with their armed flags, timers and start x.
// Depends on sgd_pkg; reads the frame queue and writes the result queue.
`timescale 1ns / 1ps

module sgd_back #(
    parameter int TIME_WIDTH = sgd_pkg::TIME_WIDTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    input  sgd_pkg::t_cls                    i_cls,
    input  logic [TIME_WIDTH-1:0]            i_time,
    input  logic [sgd_pkg::DUR_W-1:0]        i_min_dur,
    input  logic [sgd_pkg::DUR_W-1:0]        i_max_dur,
    input  logic                             i_out_full,
    output logic                             o_pop,
    output logic [sgd_pkg::GESTURE_W-1:0]    o_gesture
);

    localparam int ND = sgd_pkg::NUM_DET;
    localparam int CW = sgd_pkg::COORD_W;

    logic [ND-1:0]         r_armed;
    logic [ND-1:0]         r_running;
    logic [TIME_WIDTH-1:0] r_start [ND];
    logic signed [CW-1:0]  r_vsx   [2];

    logic [ND-1:0]         n_armed;
    logic [ND-1:0]         n_running;
    logic [TIME_WIDTH-1:0] n_start [ND];
    logic signed [CW-1:0]  n_vsx   [2];

    logic [TIME_WIDTH-1:0] elapsed [ND];
    logic [ND-1:0]         ok, cancel, arm_now, end_pos, armed_after, fire, en, hit;
    logic signed [CW-1:0]  hx [2];
    logic signed [CW:0]    dx [2];
    logic [CW:0]           adx [2];
    logic [1:0]            far;
    sgd_pkg::t_gesture     gest;

    assign o_pop = i_valid && !i_out_full;
    assign hx[0] = i_cls.hx_l;
    assign hx[1] = i_cls.hx_r;

    // Timer windows, one subtractor per detector
    always_comb begin
        for (int d = 0; d < ND; d++) begin
            elapsed[d] = r_running[d] ? (i_time - r_start[d]) : '0;
            ok[d]      = elapsed[d] > TIME_WIDTH'(i_min_dur)
                      && elapsed[d] < TIME_WIDTH'(i_max_dur);
        end
    end

    // Sideways drift of each hand against its stored start x
    always_comb begin
        for (int s = 0; s < 2; s++) begin
            dx[s]  = $signed({r_vsx[s][CW-1], r_vsx[s]}) - $signed({hx[s][CW-1], hx[s]});
            adx[s] = dx[s][CW] ? (CW+1)'(-dx[s]) : dx[s];
            far[s] = adx[s] > {1'b0, i_cls.hip_half};
        end
    end

    // Detector decisions in priority order; a fired detector masks the rest
    always_comb begin
        arm_now[sgd_pkg::D_LEFT]  = i_cls.l_arm;
        end_pos[sgd_pkg::D_LEFT]  = i_cls.l_end;
        cancel[sgd_pkg::D_LEFT]   = i_cls.l_cancel;
        arm_now[sgd_pkg::D_RIGHT] = i_cls.r_arm;
        end_pos[sgd_pkg::D_RIGHT] = i_cls.r_end;
        cancel[sgd_pkg::D_RIGHT]  = i_cls.r_cancel;
        for (int s = 0; s < 2; s++) begin
            arm_now[sgd_pkg::D_UPL + s]   = i_cls.up_arm[s];
            end_pos[sgd_pkg::D_UPL + s]   = i_cls.up_end[s];
            arm_now[sgd_pkg::D_DOWNL + s] = i_cls.dn_arm[s];
            end_pos[sgd_pkg::D_DOWNL + s] = i_cls.dn_end[s];
        end

        en     = '0;
        cancel[sgd_pkg::D_UPL]   = !i_cls.up_arm[0] && far[0];
        cancel[sgd_pkg::D_UPR]   = !i_cls.up_arm[1] && far[1];
        cancel[sgd_pkg::D_DOWNL] = 1'b0;
        cancel[sgd_pkg::D_DOWNR] = 1'b0;
        armed_after = '0;
        fire        = '0;
        en[0] = 1'b1;
        for (int d = 0; d < ND; d++) begin
            if (d >= sgd_pkg::D_DOWNL) begin
                // Down shares start x with the up detector of the same hand,
                // which may have just restarted it at the current x
                cancel[d] = !arm_now[d] && far[d - sgd_pkg::D_DOWNL]
                         && !(en[d - 2] && arm_now[d - 2]);
            end
            armed_after[d] = !cancel[d] && (r_armed[d] || arm_now[d]);
            fire[d]        = armed_after[d] && end_pos[d] && ok[d];
            if (d < ND - 1) begin
                en[d + 1] = en[d] && !fire[d];
            end
        end
        hit = en & fire;
    end

    // Next detector state
    always_comb begin
        n_armed   = r_armed;
        n_running = r_running;
        for (int d = 0; d < ND; d++) begin
            n_start[d] = r_start[d];
            if (en[d]) begin
                if (cancel[d] || fire[d]) begin
                    n_armed[d]   = 1'b0;
                    n_running[d] = 1'b0;
                end else if (armed_after[d]) begin
                    n_armed[d]   = 1'b1;
                    n_running[d] = 1'b1;
                    if (!r_running[d]) begin
                        n_start[d] = i_time;
                    end
                end
            end
        end
        for (int s = 0; s < 2; s++) begin
            n_vsx[s] = r_vsx[s];
            if ((en[sgd_pkg::D_UPL + s] && arm_now[sgd_pkg::D_UPL + s])
                || (en[sgd_pkg::D_DOWNL + s] && arm_now[sgd_pkg::D_DOWNL + s])) begin
                n_vsx[s] = hx[s];
            end
        end
    end

    // Gesture code of this frame
    always_comb begin
        if (hit[sgd_pkg::D_LEFT]) begin
            gest = sgd_pkg::GEST_LEFT;
        end else if (hit[sgd_pkg::D_RIGHT]) begin
            gest = sgd_pkg::GEST_RIGHT;
        end else if (hit[sgd_pkg::D_UPL] || hit[sgd_pkg::D_UPR]) begin
            gest = sgd_pkg::GEST_UP;
        end else if (hit[sgd_pkg::D_DOWNL] || hit[sgd_pkg::D_DOWNR]) begin
            gest = sgd_pkg::GEST_DOWN;
        end else begin
            gest = sgd_pkg::GEST_NONE;
        end
    end

    assign o_gesture = gest;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed   <= '0;
            r_running <= '0;
            for (int d = 0; d < ND; d++) begin
                r_start[d] <= '0;
            end
            r_vsx[0] <= '0;
            r_vsx[1] <= '0;
        end else if (o_pop) begin
            r_armed   <= n_armed;
            r_running <= n_running;
            for (int d = 0; d < ND; d++) begin
                r_start[d] <= n_start[d];
            end
            r_vsx[0] <= n_vsx[0];
            r_vsx[1] <= n_vsx[1];
        end
    end

endmodule

// ===== src/skeleton_swipe_gesture_detector.sv =====
// skeleton_swipe_gesture_detector: top level with the configuration registers.
// Depends on sgd_pkg, sgd_fifo, sgd_front and sgd_back.
`timescale 1ns / 1ps

// Joints enter one beat per clock through push/full while full is low; the
// beat carrying frame_end yields exactly one gesture beat (0 none, 1 left,
// 2 right, 3 up, 4 down) on the empty/pop side, every other beat yields none.
// The joint store and its compares take one beat each cycle; the detector
// unit evaluates one frame per cycle while the result queue has room, so the
// sustained rate is one beat per cycle. A frame result passes through the
// frame queue and then the result queue before it shows on the empty/pop side.
// A four-entry frame queue and a two-entry result queue let both sides stall
// independently. Write min/max durations only while no frame is pending.
module skeleton_swipe_gesture_detector #(
    parameter int TIME_WIDTH = sgd_pkg::TIME_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                push,
    output logic                                full,
    input  logic [sgd_pkg::ID_W-1:0]            i_joint_id,
    input  logic signed [sgd_pkg::COORD_W-1:0]  i_joint_x,
    input  logic signed [sgd_pkg::COORD_W-1:0]  i_joint_y,
    input  logic [sgd_pkg::IN_TIME_W-1:0]       i_frame_time_ms,
    input  logic                                i_frame_end,
    output logic                                empty,
    input  logic                                pop,
    output logic [sgd_pkg::GESTURE_W-1:0]       o_gesture,
    input  logic                                i_cfg_wr_en,
    input  logic [sgd_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [sgd_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    localparam int CLS_W = $bits(sgd_pkg::t_cls);
    localparam int MID_W = TIME_WIDTH + CLS_W;

    logic [sgd_pkg::DUR_W-1:0] r_min_dur;
    logic [sgd_pkg::DUR_W-1:0] r_max_dur;

    logic                          in_accept;
    logic                          rec_push;
    sgd_pkg::t_cls                 front_cls;
    logic [TIME_WIDTH-1:0]         front_time;
    logic                          mid_full, mid_empty, mid_pop;
    logic [MID_W-1:0]              mid_rd_data;
    logic                          out_full;
    logic [sgd_pkg::GESTURE_W-1:0] back_gesture;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_dur <= sgd_pkg::MIN_DUR_RESET;
            r_max_dur <= sgd_pkg::MAX_DUR_RESET;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_idx)
                sgd_pkg::CFG_MIN_DUR: r_min_dur <= i_cfg_data;
                sgd_pkg::CFG_MAX_DUR: r_max_dur <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // The frame queue's full flag is the input full flag
    assign full      = mid_full;
    assign in_accept = push && !mid_full;

    sgd_front #(
        .TIME_WIDTH(TIME_WIDTH)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (in_accept),
        .i_joint_id     (i_joint_id),
        .i_joint_x      (i_joint_x),
        .i_joint_y      (i_joint_y),
        .i_frame_time_ms(i_frame_time_ms),
        .i_frame_end    (i_frame_end),
        .o_rec_push     (rec_push),
        .o_cls          (front_cls),
        .o_time         (front_time)
    );

    // Frame queue between classification and detection
    sgd_fifo #(
        .WIDTH(MID_W),
        .DEPTH(sgd_pkg::MID_DEPTH)
    ) u_mid_q (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (rec_push),
        .i_wr_data({front_time, front_cls}),
        .o_full   (mid_full),
        .i_pop    (mid_pop),
        .o_rd_data(mid_rd_data),
        .o_empty  (mid_empty)
    );

    sgd_back #(
        .TIME_WIDTH(TIME_WIDTH)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (!mid_empty),
        .i_cls     (sgd_pkg::t_cls'(mid_rd_data[CLS_W-1:0])),
        .i_time    (mid_rd_data[MID_W-1:CLS_W]),
        .i_min_dur (r_min_dur),
        .i_max_dur (r_max_dur),
        .i_out_full(out_full),
        .o_pop     (mid_pop),
        .o_gesture (back_gesture)
    );

    // Result queue
    sgd_fifo #(
        .WIDTH(sgd_pkg::GESTURE_W),
        .DEPTH(sgd_pkg::OUT_DEPTH)
    ) u_out_q (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (mid_pop),
        .i_wr_data(back_gesture),
        .o_full   (out_full),
        .i_pop    (pop),
        .o_rd_data(o_gesture),
        .o_empty  (empty)
    );

`ifndef SYNTH
    // A frame leaves the frame queue only when its result has room
    a_no_out_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mid_pop |-> !out_full)
        else $error("frame consumed while result queue full");

    // An accepted frame_end beat is pending in the frame queue next cycle
    a_frame_queued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !full && i_frame_end) |=> !mid_empty)
        else $error("frame_end beat not queued");

    // Reset leaves no result pending and the input side open
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("queues not cleared by reset");
`endif

endmodule

// ===== sim/tb.sv =====
// tb: self-checking bench for skeleton_swipe_gesture_detector.
// Joint beats go in through push/full. Gesture beats are popped and compared with a
// model of the six swipe detectors held in this file. Depends on sgd_pkg and the RTL.
`timescale 1ns / 1ps

module tb;
    import sgd_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 8;
    localparam int PHASE_BEATS   = 175;
    localparam int N_SETTINGS    = 7;
    localparam int QUIET_PHASE   = 5;
    localparam int STALL_PCT     = 34;

    // register indexes that the block decodes to nothing, and the highest joint id
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;
    localparam logic [ID_W-1:0]      JOINT_ID_TOP = 4'd15;

    typedef struct {
        logic [ID_W-1:0]           id;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic [IN_TIME_W-1:0]      t;
        logic                      fe;
    } t_joint_beat;

    // DUT ports
    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      push = 1'b0;
    logic                      full;
    logic [ID_W-1:0]           i_joint_id = '0;
    logic signed [COORD_W-1:0] i_joint_x = '0;
    logic signed [COORD_W-1:0] i_joint_y = '0;
    logic [IN_TIME_W-1:0]      i_frame_time_ms = '0;
    logic                      i_frame_end = 1'b0;
    logic                      empty;
    logic                      pop = 1'b0;
    logic [GESTURE_W-1:0]      o_gesture;
    logic                      i_cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]      i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0]     i_cfg_data = '0;

    skeleton_swipe_gesture_detector dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_joint_id     (i_joint_id),
        .i_joint_x      (i_joint_x),
        .i_joint_y      (i_joint_y),
        .i_frame_time_ms(i_frame_time_ms),
        .i_frame_end    (i_frame_end),
        .empty          (empty),
        .pop            (pop),
        .o_gesture      (o_gesture),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data)
    );

    // Bench state
    t_joint_beat  joint_backlog[$];
    t_gesture     gestures_due[$];
    int           stall_pct = STALL_PCT;
    int           mismatches = 0;
    int           beats_planned = 0;
    int           beats_sent = 0;
    int           frames_checked = 0;
    int           settings_done = 0;
    int           hits[5];
    int           cycles = 0;
    logic [31:0]  clock_ms = '0;
    logic [15:0]  lo_plan [0:N_SETTINGS-1] =
        '{16'd100, 16'd0, 16'd65535, 16'd500, 16'd0, 16'd50, 16'd200};
    logic [15:0]  hi_plan [0:N_SETTINGS-1] =
        '{16'd1000, 16'd65535, 16'd65535, 16'd200, 16'd0, 16'd400, 16'd3000};

    // Gesture model: joint store, detector flags, timers, durations
    int           pose_x[NUM_JOINTS];
    int           pose_y[NUM_JOINTS];
    logic [5:0]   armed = '0;
    logic [5:0]   timing = '0;
    logic [31:0]  t_start[NUM_DET];
    int           anchor_x[2];
    logic [15:0]  dur_lo = MIN_DUR_RESET;
    logic [15:0]  dur_hi = MAX_DUR_RESET;

    function automatic void drop(int d);
        armed[d]   = 1'b0;
        timing[d]  = 1'b0;
        t_start[d] = '0;
    endfunction

    // Starts the timer on first use; true when elapsed time is inside the window
    function automatic bit in_window(int d, logic [31:0] now);
        logic [31:0] el;
        if (!timing[d]) begin
            timing[d]  = 1'b1;
            t_start[d] = now;
        end
        el = now - t_start[d];
        return (el > {16'd0, dur_lo}) && (el < {16'd0, dur_hi});
    endfunction

    // Right hand sweeping toward the torso
    function automatic bit rhand_sweep(logic [31:0] now);
        int hx, hy;
        bit ok;
        hx = pose_x[J_RHAND];
        hy = pose_y[J_RHAND];
        if (hy < pose_y[J_RELBOW] || hy > pose_y[J_HEAD] || hy < pose_y[J_RHIP]) begin
            drop(D_LEFT);
            return 1'b0;
        end
        if (hx >= pose_x[J_RSHOULDER]) begin
            if (hx - pose_x[J_RSHOULDER] > hx - pose_x[J_TORSO]) begin
                drop(D_LEFT);
                return 1'b0;
            end
            armed[D_LEFT] = 1'b1;
        end
        if (armed[D_LEFT]) begin
            ok = in_window(D_LEFT, now);
            if (hx <= pose_x[J_TORSO] && ok) begin
                drop(D_LEFT);
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // Left hand sweeping toward the torso
    function automatic bit lhand_sweep(logic [31:0] now);
        int hx, hy;
        bit ok;
        hx = pose_x[J_LHAND];
        hy = pose_y[J_LHAND];
        if (hy < pose_y[J_LELBOW] || hy > pose_y[J_HEAD] || hy < pose_y[J_LHIP]) begin
            drop(D_RIGHT);
            return 1'b0;
        end
        if (hx <= pose_x[J_LSHOULDER]) begin
            if (hx - pose_x[J_LSHOULDER] < pose_x[J_LSHOULDER] - pose_x[J_TORSO]) begin
                drop(D_RIGHT);
                return 1'b0;
            end
            armed[D_RIGHT] = 1'b1;
        end
        if (armed[D_RIGHT]) begin
            ok = in_window(D_RIGHT, now);
            if (hx >= pose_x[J_TORSO] && ok) begin
                drop(D_RIGHT);
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // Up or down sweep of one hand; both directions share the hand's start x
    function automatic bit swipe_vertical(int d, int side, bit up, logic [31:0] now);
        int hand, elb, sho, hip, hx, hy, spread, dev;
        bit arm_now, end_pos, ok;
        hand = side ? J_RHAND : J_LHAND;
        elb  = side ? J_RELBOW : J_LELBOW;
        sho  = side ? J_RSHOULDER : J_LSHOULDER;
        hip  = side ? J_RHIP : J_LHIP;
        hx   = pose_x[hand];
        hy   = pose_y[hand];
        if (up)
            arm_now = hy <= pose_y[elb] && hy <= pose_y[hip];
        else
            arm_now = hy >= pose_y[elb] && hy >= pose_y[sho];
        if (arm_now) begin
            armed[d]       = 1'b1;
            anchor_x[side] = hx;
        end
        spread = pose_x[J_LHIP] - pose_x[J_RHIP];
        if (spread < 0) spread = -spread;
        spread = spread / 2;
        dev = anchor_x[side] - hx;
        if (dev < 0) dev = -dev;
        if (dev > spread) begin
            drop(d);
            return 1'b0;
        end
        if (armed[d]) begin
            ok = in_window(d, now);
            if (up)
                end_pos = hy > pose_y[elb] && hy > pose_y[sho];
            else
                end_pos = hy < pose_y[elb] && hy < pose_y[hip];
            if (end_pos && ok) begin
                drop(d);
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // Detectors in priority order; later ones are skipped after a hit
    function automatic t_gesture next_gesture(logic [31:0] now);
        if (rhand_sweep(now))                        return GEST_LEFT;
        else if (lhand_sweep(now))                   return GEST_RIGHT;
        else if (swipe_vertical(D_UPL, 0, 1, now))   return GEST_UP;
        else if (swipe_vertical(D_UPR, 1, 1, now))   return GEST_UP;
        else if (swipe_vertical(D_DOWNL, 0, 0, now)) return GEST_DOWN;
        else if (swipe_vertical(D_DOWNR, 1, 0, now)) return GEST_DOWN;
        return GEST_NONE;
    endfunction

    // Apply one accepted joint beat to the model
    function automatic void take_beat(logic [ID_W-1:0] id, logic signed [COORD_W-1:0] x,
                                      logic signed [COORD_W-1:0] y, logic [31:0] t,
                                      logic fe);
        if (id < NUM_JOINTS) begin
            pose_x[id] = x;
            pose_y[id] = y;
        end
        if (fe)
            gestures_due.push_back(next_gesture(t));
    endfunction

    // Stimulus building
    function automatic void queue_beat(logic [ID_W-1:0] id, int x, int y, logic [31:0] t,
                                       logic fe);
        t_joint_beat b;
        b.id = id;
        b.x  = x[15:0];
        b.y  = y[15:0];
        b.t  = t;
        b.fe = fe;
        joint_backlog.push_back(b);
        beats_planned++;
    endfunction

    function automatic int jitter();
        return int'($urandom_range(16)) - 8;
    endfunction

    // Nominal standing body; hands come from the caller
    function automatic void joint_pose(input int id, input int lhx, lhy, rhx, rhy,
                                       output int x, output int y);
        case (id)
            J_HEAD:      begin x = 0;    y = 500; end
            J_TORSO:     begin x = 0;    y = 200; end
            J_LHAND:     begin x = lhx;  y = lhy; end
            J_RHAND:     begin x = rhx;  y = rhy; end
            J_LELBOW:    begin x = -150; y = 250; end
            J_RELBOW:    begin x = 150;  y = 250; end
            J_LSHOULDER: begin x = -100; y = 350; end
            J_RSHOULDER: begin x = 100;  y = 350; end
            J_LHIP:      begin x = -80;  y = 0;   end
            default:     begin x = 80;   y = 0;   end
        endcase
        x = x + jitter();
        y = y + jitter();
    endfunction

    // One frame in shuffled joint order; count below ten gives a broken frame
    function automatic void queue_frame(int lhx, int lhy, int rhx, int rhy, int count);
        int order[NUM_JOINTS];
        int k, j, tmp, x, y;
        for (k = 0; k < NUM_JOINTS; k++) order[k] = k;
        for (k = NUM_JOINTS - 1; k > 0; k--) begin
            j        = $urandom_range(k, 0);
            tmp      = order[k];
            order[k] = order[j];
            order[j] = tmp;
        end
        for (k = 0; k < count; k++) begin
            joint_pose(order[k], lhx, lhy, rhx, rhy, x, y);
            queue_beat(order[k][ID_W-1:0], x, y, clock_ms, k == count - 1);
        end
    endfunction

    // Frame spacing scaled to the current window so swipes land on both sides of it
    function automatic void advance_clock();
        if ($urandom_range(11, 0) == 0)
            clock_ms = 32'hFFFF_FFFF - $urandom_range(1500, 0);
        else
            clock_ms = clock_ms + $urandom_range(int'(dur_hi) / 2 + 3, 0);
    endfunction

    function automatic void queue_noise();
        int n, k;
        n = $urandom_range(4, 1);
        for (k = 0; k < n; k++)
            queue_beat(ID_W'($urandom_range(JOINT_ID_TOP, 0)), $urandom, $urandom,
                       $urandom, 1'($urandom_range(1, 0)));
    endfunction

    // A swipe attempt: a few frames in the start pose, then a few in the end pose
    function automatic void queue_attempt();
        int kind, side, k, n_from, n_to, cnt;
        int s_lx, s_ly, s_rx, s_ry, e_lx, e_ly, e_rx, e_ry;
        kind = $urandom_range(5, 0);
        side = $urandom_range(1, 0);
        s_lx = -120; s_ly = -50; s_rx = 120; s_ry = -50;
        case (kind)
            0: begin s_rx = 200; s_ry = 300; end
            1: begin s_lx = -150; s_ly = 300; end
            2: if (side) s_ry = -50; else s_ly = -50;
            3: if (side) s_ry = 450; else s_ly = 450;
            4: begin
                s_lx = $urandom_range(600) - 300; s_ly = $urandom_range(700) - 150;
                s_rx = $urandom_range(600) - 300; s_ry = $urandom_range(700) - 150;
            end
            default: ;
        endcase
        e_lx = s_lx; e_ly = s_ly; e_rx = s_rx; e_ry = s_ry;
        case (kind)
            0: e_rx = -50;
            1: e_lx = 50;
            2: if (side) e_ry = 420; else e_ly = 420;
            3: if (side) e_ry = -50; else e_ly = -50;
            4: begin
                e_lx = $urandom_range(600) - 300; e_ly = $urandom_range(700) - 150;
                e_rx = $urandom_range(600) - 300; e_ry = $urandom_range(700) - 150;
            end
            default: ;
        endcase
        n_from = $urandom_range(3, 1);
        n_to   = $urandom_range(2, 1);
        for (k = 0; k < n_from + n_to; k++) begin
            advance_clock();
            cnt = ($urandom_range(9, 0) == 0) ? $urandom_range(NUM_JOINTS - 1, 1)
                                              : NUM_JOINTS;
            if (k < n_from) queue_frame(s_lx, s_ly, s_rx, s_ry, cnt);
            else            queue_frame(e_lx, e_ly, e_rx, e_ry, cnt);
        end
        if ($urandom_range(99, 0) < 15) queue_noise();
    endfunction

    // Register write while the block is idle; the model follows
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        if (idx == CFG_MIN_DUR)      dur_lo = val;
        else if (idx == CFG_MAX_DUR) dur_hi = val;
    endtask

    // Wait until every beat is in and every gesture is out, then let the pipe settle
    task automatic drain();
        do @(posedge i_clk);
        while (joint_backlog.size() != 0 || push || gestures_due.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Clock
    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Cycle limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d gestures still due, %0d beats unsent",
                     $time, gestures_due.size(), joint_backlog.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Driver: one joint beat per push, held while full
    always @(posedge i_clk) begin : drive_joints
        t_joint_beat nxt;
        if (!i_rst_n) begin
            push <= 1'b0;
        end else begin
            if (push && !full)
                take_beat(i_joint_id, i_joint_x, i_joint_y, i_frame_time_ms, i_frame_end);
            if (!push || !full) begin
                if (joint_backlog.size() != 0 && $urandom_range(99, 0) >= stall_pct) begin
                    nxt = joint_backlog.pop_front();
                    i_joint_id      <= nxt.id;
                    i_joint_x       <= nxt.x;
                    i_joint_y       <= nxt.y;
                    i_frame_time_ms <= nxt.t;
                    i_frame_end     <= nxt.fe;
                    push            <= 1'b1;
                    beats_sent++;
                end else begin
                    push <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each popped gesture with the oldest one due
    always @(posedge i_clk) begin : check_gestures
        t_gesture want;
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (gestures_due.size() == 0) begin
                    $display("%0t: gesture beat with none due, expected nothing, got %0d",
                             $time, o_gesture);
                    mismatches++;
                end else begin
                    want = gestures_due.pop_front();
                    if (o_gesture !== want) begin
                        $display("%0t: gesture mismatch, expected %0d, got %0d",
                                 $time, want, o_gesture);
                        mismatches++;
                    end
                    hits[want]++;
                    frames_checked++;
                end
            end
            pop <= ($urandom_range(99, 0) >= stall_pct);
        end
    end

    // Sequence: reset, directed beats, then one phase per duration setting
    initial begin : run
        int p, k, mark;
        for (k = 0; k < NUM_JOINTS; k++) begin
            pose_x[k] = 0;
            pose_y[k] = 0;
        end
        for (k = 0; k < NUM_DET; k++) t_start[k] = '0;
        anchor_x[0] = 0;
        anchor_x[1] = 0;
        for (k = 0; k < 5; k++) hits[k] = 0;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // field extremes, an evaluation on a reset store, unused ids with frame end
        queue_beat(ID_W'(J_HEAD), 32767, 32767, 32'd0, 1'b0);
        queue_beat(ID_W'(J_TORSO), -32768, -32768, 32'd0, 1'b1);
        queue_beat(JOINT_ID_TOP, 16'h5555, 16'hAAAA, 32'hFFFF_FFFF, 1'b1);
        queue_beat(ID_W'(NUM_JOINTS), -1, 0, 32'h8000_0000, 1'b1);
        // left swipe across the timestamp wrap
        clock_ms = 32'hFFFF_FFC0;
        queue_frame(-120, -50, 200, 300, NUM_JOINTS);
        queue_beat(ID_W'(J_RHAND), -50, 300, 32'h0000_0100, 1'b1);
        // up swipe with the left hand, end frame right at the minimum then past it
        queue_beat(ID_W'(J_LHAND), -120, 420, 32'h0000_0200, 1'b1);
        queue_beat(ID_W'(J_LHAND), -120, -50, 32'h0000_0300, 1'b1);
        queue_beat(ID_W'(J_LHAND), -120, 420, 32'h0000_0364, 1'b1);
        queue_beat(ID_W'(J_LHAND), -120, 420, 32'h0000_0365, 1'b1);
        clock_ms = 32'h0000_0400;

        for (p = 0; p < N_SETTINGS; p++) begin
            drain();
            stall_pct = (p == QUIET_PHASE) ? 0 : STALL_PCT;
            write_reg(CFG_MIN_DUR, lo_plan[p]);
            write_reg(CFG_MAX_DUR, hi_plan[p]);
            if (p == 3) begin
                write_reg(CFG_SPARE_A, 16'($urandom));
                write_reg(CFG_SPARE_B, 16'($urandom));
            end
            settings_done++;
            mark = beats_planned;
            while (beats_planned - mark < PHASE_BEATS)
                queue_attempt();
        end
        drain();

        $display("Sent %0d joint beats over %0d duration settings; %0d frames checked",
                 beats_sent, settings_done, frames_checked);
        $display("Gestures seen: none %0d, left %0d, right %0d, up %0d, down %0d",
                 hits[GEST_NONE], hits[GEST_LEFT], hits[GEST_RIGHT], hits[GEST_UP],
                 hits[GEST_DOWN]);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
